// ===== hdl/srpg_pkg.sv =====
// Package for the stepper ramp pulse generator: request and result types,
// configuration register indexes, reset values and widths.
// No dependencies.
package srpg_pkg;

	localparam int unsigned IntervalW  = 8;
	localparam int unsigned TimeoutW   = 16;
	localparam int unsigned PosOutW    = 16;
	localparam int unsigned CfgIndexW  = 3;
	localparam int unsigned CfgDataW   = 16;
	localparam int unsigned PositionBitsDefault = 16;

	localparam logic [CfgIndexW-1:0] RegFastInterval  = 3'd0;
	localparam logic [CfgIndexW-1:0] RegSlowInterval  = 3'd1;
	localparam logic [CfgIndexW-1:0] RegRampCeiling   = 3'd2;
	localparam logic [CfgIndexW-1:0] RegTimeoutReload = 3'd3;

	localparam logic [IntervalW-1:0] FastIntervalRst  = 8'd1;
	localparam logic [IntervalW-1:0] SlowIntervalRst  = 8'd30;
	localparam logic [IntervalW-1:0] RampCeilingRst   = 8'd40;
	localparam logic [TimeoutW-1:0]  TimeoutReloadRst = 16'd20000;
	localparam logic [IntervalW-1:0] WidthCountRst    = 8'd40;

	typedef struct packed {
		logic run;
		logic speed_high;
		logic dir_left;
		logic clear_position;
		logic timeout_start;
	} tick_t;

	typedef struct packed {
		logic                 step_pin;
		logic                 step_toggled;
		logic [PosOutW-1:0]   position;
		logic [IntervalW-1:0] current_interval;
		logic                 timeout_done;
	} result_t;

	typedef struct packed {
		logic [IntervalW-1:0] fast_interval;
		logic [IntervalW-1:0] slow_interval;
		logic [IntervalW-1:0] ramp_ceiling;
		logic [TimeoutW-1:0]  timeout_reload;
	} cfg_t;

	typedef struct packed {
		logic [IntervalW-1:0] width_count;
		logic                 pin_level;
	} status_t;

endpackage

// ===== hdl/stepper_ramp_pulse_generator.sv =====
// Top level of the stepper ramp pulse generator: configuration registers,
// request register, tick engine and result register. Depends on srpg_pkg, srpg_tick.
//
//  Channel   Signals                          Payload
//  request   tick_valid / tick_ready          tick (tick_t)
//  result    res_valid / res_ready            res (result_t)
//  config    cfg_we                           cfg_index, cfg_data
//
// A request is held in the request register while the tick engine works on it, and its
// result is then registered in the result register until it is taken. One request per
// cycle is sustained while results are taken; the tick engine updates all state whenever
// a request advances.
// Reset clears the state to the ceiling interval, zero position and expired timeout.
// A stalled result holds the request register full, after which tick_ready drops.
module stepper_ramp_pulse_generator import srpg_pkg::*; #(
	parameter int unsigned POSITION_BITS = PositionBitsDefault
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_valid,
	output logic                 tick_ready,
	input  tick_t                tick,
	output logic                 res_valid,
	input  logic                 res_ready,
	output result_t              res,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	cfg_t    cfg_q;
	tick_t   tick_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	result_t eng_res;
	status_t status;

	assign advance    = valid_s1 && (!valid_s2 || res_ready);
	assign tick_ready = !valid_s1 || advance;
	assign res_valid  = valid_s2;
	assign res        = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fast_interval  <= FastIntervalRst;
			cfg_q.slow_interval  <= SlowIntervalRst;
			cfg_q.ramp_ceiling   <= RampCeilingRst;
			cfg_q.timeout_reload <= TimeoutReloadRst;
		end else if (cfg_we) begin
			case (cfg_index)
				RegFastInterval:  cfg_q.fast_interval  <= cfg_data[IntervalW-1:0];
				RegSlowInterval:  cfg_q.slow_interval  <= cfg_data[IntervalW-1:0];
				RegRampCeiling:   cfg_q.ramp_ceiling   <= cfg_data[IntervalW-1:0];
				RegTimeoutReload: cfg_q.timeout_reload <= cfg_data[TimeoutW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (tick_ready) begin
				valid_s1 <= tick_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (res_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && tick_ready) begin
			tick_s1 <= tick;
		end
		if (advance) begin
			res_s2 <= eng_res;
		end
	end

	srpg_tick #(
		.POSITION_BITS(POSITION_BITS)
	) u_tick (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (advance),
		.tick  (tick_s1),
		.cfg   (cfg_q),
		.res   (eng_res),
		.status(status)
	);

	a_fill_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !valid_s2) |=> valid_s2)
		else $error("Full request register did not move into an empty result register.");

	a_drain_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_ready && !valid_s1) |=> !valid_s2)
		else $error("Taken result stayed valid with nothing behind it.");

	a_pulse_clears_width: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eng_res.step_toggled) |=> (status.width_count == '0))
		else $error("Width counter not cleared after a pulse.");

	a_pin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !eng_res.step_toggled) |=> (status.pin_level == $past(status.pin_level)))
		else $error("Step pin changed without a pulse.");

endmodule

// ===== hdl/srpg_tick.sv =====
// Tick engine: holds the ramp, pulse, position and timeout state and
// advances it by one request per enabled cycle.
// Depends on srpg_pkg.
module srpg_tick import srpg_pkg::*; #(
	parameter int unsigned POSITION_BITS = PositionBitsDefault
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  tick_t   tick,
	input  cfg_t    cfg,
	output result_t res,
	output status_t status
);

	logic [IntervalW-1:0]     interval_q;
	logic [IntervalW-1:0]     width_count_q;
	logic                     pin_level_q;
	logic                     half_phase_q;
	logic [POSITION_BITS-1:0] position_q;
	logic [TimeoutW-1:0]      timeout_q;

	logic [IntervalW-1:0]     target;
	logic [IntervalW-1:0]     iv0;
	logic [IntervalW-1:0]     iv_n;
	logic [IntervalW-1:0]     wc_inc;
	logic [IntervalW-1:0]     wc_n;
	logic                     pulse;
	logic                     half_n;
	logic [POSITION_BITS-1:0] pos0;
	logic [POSITION_BITS-1:0] pos_n;
	logic [TimeoutW-1:0]      to0;
	logic [TimeoutW-1:0]      to_n;
	logic [POSITION_BITS+PosOutW-1:0] pos_ext;

	always_comb begin
		target = tick.speed_high ? cfg.fast_interval : cfg.slow_interval;
		iv0 = interval_q;
		if (!tick.speed_high && (interval_q < cfg.slow_interval)) begin
			iv0 = cfg.slow_interval;
		end
		wc_inc = width_count_q + 8'd1;
		iv_n = iv0;
		wc_n = width_count_q;
		pulse = 1'b0;
		if (tick.run) begin
			wc_n = wc_inc;
			if (wc_inc >= iv0) begin
				pulse = 1'b1;
				if (iv0 > target) begin
					iv_n = iv0 - 8'd1;
				end
			end
		end else if (width_count_q >= iv0) begin
			if (iv0 < cfg.ramp_ceiling) begin
				iv_n = iv0 + 8'd1;
				pulse = 1'b1;
			end
		end else begin
			wc_n = wc_inc;
		end

		pos0 = tick.clear_position ? '0 : position_q;
		pos_n = pos0;
		half_n = half_phase_q;
		if (pulse) begin
			wc_n = '0;
			half_n = ~half_phase_q;
			if (half_phase_q) begin
				if (!tick.dir_left) begin
					if (pos0 != '1) begin
						pos_n = pos0 + 1'b1;
					end
				end else if (pos0 != '0) begin
					pos_n = pos0 - 1'b1;
				end
			end
		end

		to0 = tick.timeout_start ? cfg.timeout_reload : timeout_q;
		to_n = (to0 != '0) ? to0 - 16'd1 : '0;
		pos_ext = {{PosOutW{1'b0}}, pos_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q    <= RampCeilingRst;
			width_count_q <= WidthCountRst;
			pin_level_q   <= 1'b0;
			half_phase_q  <= 1'b0;
			position_q    <= '0;
			timeout_q     <= '0;
		end else if (en) begin
			interval_q    <= iv_n;
			width_count_q <= wc_n;
			pin_level_q   <= pin_level_q ^ pulse;
			half_phase_q  <= half_n;
			position_q    <= pos_n;
			timeout_q     <= to_n;
		end
	end

	always_comb begin
		res.step_pin         = pin_level_q ^ pulse;
		res.step_toggled     = pulse;
		res.position         = pos_ext[PosOutW-1:0];
		res.current_interval = iv_n;
		res.timeout_done     = (to_n == '0);
		status.width_count   = width_count_q;
		status.pin_level     = pin_level_q;
	end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for stepper_ramp_pulse_generator: it predicts every tick's result
// and compares it with the result channel, under random idling on both sides.
// Depends on srpg_pkg and the RTL of the block only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import srpg_pkg::*;

	localparam int unsigned StallLimit = 2000;
	localparam logic [CfgIndexW-1:0] RegLastUnused = '1;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 tick_valid = 1'b0;
	logic                 tick_ready;
	tick_t                tick = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	result_t              res;
	logic                 cfg_we = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0]  cfg_data = '0;

	stepper_ramp_pulse_generator uut (
		.clk,
		.arst_n,
		.tick_valid,
		.tick_ready,
		.tick,
		.res_valid,
		.res_ready,
		.res,
		.cfg_we,
		.cfg_index,
		.cfg_data
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Motor state as the block should hold it.
	cfg_t                           cfg_now = '{FastIntervalRst, SlowIntervalRst,
	                                             RampCeilingRst, TimeoutReloadRst};
	logic [IntervalW-1:0]           step_ivl = RampCeilingRst;
	logic [IntervalW-1:0]           width_cnt = WidthCountRst;
	logic                           pin_level = 1'b0;
	logic                           half_phase = 1'b0;
	logic [PositionBitsDefault-1:0] step_pos = '0;
	logic [TimeoutW-1:0]            timeout_left = '0;

	tick_t       tick_requests[$];
	result_t     predicted_outputs[$];
	int unsigned n_queued = 0;
	int unsigned n_checked = 0;
	int unsigned n_errors = 0;
	int unsigned n_settings = 1;
	int unsigned n_toggles = 0;
	int unsigned peak_position = 0;
	bit          steady = 1'b0;
	int unsigned send_gap = 0;
	int unsigned send_calm = 0;
	int unsigned stall_left = 0;
	int unsigned recv_calm = 0;
	int unsigned idle_cycles = 0;

	function automatic result_t advance_motor(tick_t t);
		result_t              r;
		logic [IntervalW-1:0] target;
		logic                 pulse;
		pulse = 1'b0;
		if (t.clear_position) begin
			step_pos = '0;
		end
		if (t.timeout_start) begin
			timeout_left = cfg_now.timeout_reload;
		end
		if (t.speed_high) begin
			target = cfg_now.fast_interval;
		end else begin
			target = cfg_now.slow_interval;
			if (step_ivl < target) begin
				step_ivl = target;
			end
		end
		if (t.run) begin
			width_cnt = width_cnt + 1'b1;
			if (width_cnt >= step_ivl) begin
				if (step_ivl > target) begin
					step_ivl = step_ivl - 1'b1;
				end
				pulse = 1'b1;
			end
		end else if (width_cnt >= step_ivl) begin
			if (step_ivl < cfg_now.ramp_ceiling) begin
				step_ivl = step_ivl + 1'b1;
				pulse = 1'b1;
			end
		end else begin
			width_cnt = width_cnt + 1'b1;
		end
		if (pulse) begin
			pin_level = ~pin_level;
			if (half_phase) begin
				half_phase = 1'b0;
				if (!t.dir_left) begin
					if (step_pos != '1) begin
						step_pos = step_pos + 1'b1;
					end
				end else if (step_pos != '0) begin
					step_pos = step_pos - 1'b1;
				end
			end else begin
				half_phase = 1'b1;
			end
			width_cnt = '0;
		end
		if (timeout_left != '0) begin
			timeout_left = timeout_left - 1'b1;
		end
		r.step_pin = pin_level;
		r.step_toggled = pulse;
		r.position = step_pos[PosOutW-1:0];
		r.current_interval = step_ivl;
		r.timeout_done = (timeout_left == '0);
		return r;
	endfunction

	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned roll;
		if (steady) begin
			return 0;
		end
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm = $urandom_range(15, 60);
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end
		if (roll < 85) begin
			return $urandom_range(1, 3);
		end
		if (roll < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic check_field(input string field, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_valid && tick_ready) begin
				predicted_outputs.push_back(advance_motor(tick));
			end
			if (!tick_valid || tick_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					tick_valid <= 1'b0;
				end else if (tick_requests.size() > 0) begin
					tick <= tick_requests.pop_front();
					tick_valid <= 1'b1;
					send_gap = pick_gap(send_calm);
				end else begin
					tick_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (predicted_outputs.size() == 0) begin
					$error("Result arrived with no request outstanding: %h", res);
					n_errors++;
				end else begin
					want = predicted_outputs.pop_front();
					check_field("step_pin", 32'(want.step_pin), 32'(res.step_pin));
					check_field("step_toggled", 32'(want.step_toggled),
						32'(res.step_toggled));
					check_field("position", 32'(want.position), 32'(res.position));
					check_field("current_interval", 32'(want.current_interval),
						32'(res.current_interval));
					check_field("timeout_done", 32'(want.timeout_done),
						32'(res.timeout_done));
					n_toggles += 32'(want.step_toggled);
					if (32'(want.position) > peak_position) begin
						peak_position = 32'(want.position);
					end
				end
				n_checked++;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				if ($urandom_range(0, 1) == 0) begin
					stall_left = pick_gap(recv_calm);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((tick_valid && tick_ready) || (res_valid && res_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles == StallLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic queue_tick(input bit run, input bit speed_high, input bit dir_left,
		input bit clear_position, input bit timeout_start);
		tick_requests.push_back('{run, speed_high, dir_left, clear_position, timeout_start});
		n_queued++;
	endtask

	task automatic queue_random(input int unsigned count);
		bit          run_req;
		bit          fast_req;
		bit          left_req;
		int unsigned seg_left;
		seg_left = 0;
		repeat (count) begin
			if (seg_left == 0) begin
				run_req = ($urandom_range(0, 3) != 0);
				fast_req = 1'($urandom_range(0, 1));
				left_req = 1'($urandom_range(0, 1));
				seg_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
					: $urandom_range(1, 12);
			end
			seg_left--;
			if ($urandom_range(0, 7) == 0) begin
				queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end else begin
				queue_tick(run_req, fast_req, left_req, $urandom_range(0, 15) == 0,
					$urandom_range(0, 9) == 0);
			end
		end
	endtask

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			RegFastInterval:  cfg_now.fast_interval = value[IntervalW-1:0];
			RegSlowInterval:  cfg_now.slow_interval = value[IntervalW-1:0];
			RegRampCeiling:   cfg_now.ramp_ceiling = value[IntervalW-1:0];
			RegTimeoutReload: cfg_now.timeout_reload = value[TimeoutW-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [IntervalW-1:0] fast, input logic [IntervalW-1:0] slow,
		input logic [IntervalW-1:0] ceiling, input logic [TimeoutW-1:0] reload);
		write_reg(RegFastInterval, CfgDataW'(fast));
		write_reg(RegSlowInterval, CfgDataW'(slow));
		write_reg(RegRampCeiling, CfgDataW'(ceiling));
		write_reg(RegTimeoutReload, CfgDataW'(reload));
		n_settings++;
	endtask

	task automatic settle();
		while (n_checked < n_queued) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		queue_tick(0, 0, 0, 0, 0);
		queue_tick(0, 1, 1, 1, 1);
		queue_tick(1, 1, 0, 0, 0);
		queue_tick(1, 1, 0, 0, 0);
		queue_tick(1, 1, 1, 0, 0);
		queue_tick(0, 1, 0, 0, 0);
		queue_tick(1, 0, 1, 0, 1);
		queue_tick(1, 1, 1, 1, 1);
		queue_tick(0, 0, 1, 1, 0);
		queue_tick(1, 0, 0, 0, 0);
		queue_tick(1, 1, 0, 1, 0);
		queue_tick(0, 1, 1, 0, 1);
		queue_random(80);
		settle();

		// A gapless run toward the fastest interval ramps the interval down and lets a short
		// timeout expire.
		apply_setting(8'd1, 8'd30, 8'd40, 16'd25);
		steady = 1'b1;
		queue_tick(1, 1, 0, 1, 1);
		repeat (40) queue_tick(1, 1, 0, 0, 0);
		repeat (6) queue_tick(1, 1, 1, 0, 0);
		settle();
		steady = 1'b0;

		// Holding stopped at the widest interval lets the width counter reach its
		// top, so the next run wraps it.
		apply_setting(8'd1, 8'd255, 8'd255, 16'd0);
		repeat (260) queue_tick(0, 0, 1'($urandom_range(0, 1)), 0, 1'($urandom_range(0, 1)));
		repeat (20) queue_tick(1, 0, 1'($urandom_range(0, 1)), 0, 0);
		queue_random(20);
		settle();

		apply_setting(8'd0, 8'd1, 8'd1, 16'd1);
		queue_random(40);
		settle();

		apply_setting(8'd255, 8'd0, 8'd128, 16'hffff);
		queue_random(40);
		settle();

		apply_setting(IntervalW'($urandom_range(1, 16)), IntervalW'($urandom_range(1, 64)),
			IntervalW'($urandom_range(1, 96)), TimeoutW'($urandom_range(0, 300)));
		write_reg(CfgIndexW'($urandom_range(RegTimeoutReload + 1, RegLastUnused)),
			CfgDataW'($urandom()));
		write_reg(RegLastUnused, CfgDataW'($urandom()));
		queue_random(40);
		settle();

		apply_setting(IntervalW'($urandom_range(1, 255)), IntervalW'($urandom_range(1, 255)),
			IntervalW'($urandom_range(1, 255)), TimeoutW'($urandom_range(0, 65535)));
		queue_random(40);
		settle();

		$display("Checked %0d tick results under %0d register settings.",
			n_checked, n_settings);
		$display("The step pin toggled %0d times and the position peaked at %0d.",
			n_toggles, peak_position);
		if (n_errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/srpg_pkg.sv
hdl/srpg_tick.sv
hdl/stepper_ramp_pulse_generator.sv
tb/tb_top.sv
